FILE: rtl/brrp_pkg.sv
package brrp_pkg;

    localparam int NUM_PORTS = 64;
    localparam int PORT_W = 6;
    localparam int LINE_W = 64;
    localparam int SCAN_W = 7;
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 8;

    localparam logic [LINE_W-1:0] PORT_MASK =
        (NUM_PORTS >= LINE_W) ? {LINE_W{1'b1}}
                              : ((LINE_W'(1) << NUM_PORTS) - LINE_W'(1));

    typedef enum logic [1:0] {
        MODE_ENABLE  = 2'd0,
        MODE_DISABLE = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_REQUEST = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_SERVED = 2'd0,
        ST_NONE   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_DONE   = 2'd3
    } status_t;

endpackage

FILE: rtl/batch_round_robin_ready_picker.sv
// Batch round-robin picker over up to 64 ports. Each input transfer either edits the enable
// mask (enable, disable, disable all) or requests the next ready port, and produces exactly
// one result transfer. A request with no batch pending snapshots the enabled ready ports up
// to the highest enabled index; requests then serve that batch lowest index first until it
// is empty. One transfer is taken every clock cycle unless m_axis_tready stalls the result
// register; a result passes the input register, then the result register, and the single
// decode, snapshot and priority encode stage between those registers is what sets this rate.
module batch_round_robin_ready_picker
    import brrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // port_index[5:0], ready_lines[69:6], zero
    input  logic [1:0]            s_axis_tuser,  // mode[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // served_port[5:0], zero
    output logic [1:0]            m_axis_tuser   // status[1:0]
);

    logic              in_valid_reg;
    mode_t             mode_reg;
    logic [PORT_W-1:0] port_reg;
    logic [LINE_W-1:0] ready_reg;

    logic [LINE_W-1:0] enable_reg;
    logic [LINE_W-1:0] enable_next;
    logic [PORT_W-1:0] highest_reg;
    logic [PORT_W-1:0] highest_next;
    logic [LINE_W-1:0] batch_reg;
    logic [LINE_W-1:0] batch_next;
    logic [SCAN_W-1:0] scan_reg;
    logic [SCAN_W-1:0] scan_next;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [PORT_W-1:0] out_port_reg;

    logic              stage_fire;
    logic [LINE_W-1:0] upto;
    logic [LINE_W-1:0] snap;
    logic [LINE_W-1:0] work;
    logic [SCAN_W-1:0] work_scan;
    logic [LINE_W-1:0] above;
    logic [LINE_W-1:0] cand;
    logic [PORT_W-1:0] pick;
    logic              port_bad;
    status_t           res_status;
    logic [PORT_W-1:0] res_port;

    assign stage_fire = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || stage_fire;

    assign upto = (highest_reg == {PORT_W{1'b1}}) ? {LINE_W{1'b1}}
                : ((LINE_W'(1) << (highest_reg + PORT_W'(1))) - LINE_W'(1));
    assign snap = enable_reg & ready_reg & upto & PORT_MASK;
    assign work = (batch_reg == '0) ? snap : batch_reg;
    assign work_scan = (batch_reg == '0) ? '0 : scan_reg;
    assign above = work_scan[SCAN_W-1] ? '0
                 : ~((LINE_W'(1) << work_scan[PORT_W-1:0]) - LINE_W'(1));
    assign cand = work & upto & above;
    assign port_bad = {1'b0, port_reg} >= SCAN_W'(NUM_PORTS);

    always_comb
    begin
        pick = '0;
        for (int i = LINE_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pick = PORT_W'(i);
            end
        end
    end

    always_comb
    begin
        enable_next  = enable_reg;
        highest_next = highest_reg;
        batch_next   = batch_reg;
        scan_next    = scan_reg;
        res_status   = ST_DONE;
        res_port     = '0;
        unique case (mode_reg)
            MODE_ENABLE, MODE_DISABLE:
            begin
                if (port_bad)
                begin
                    res_status = ST_RANGE;
                end
                else if (mode_reg == MODE_ENABLE)
                begin
                    enable_next[port_reg] = 1'b1;
                    if (port_reg > highest_reg)
                    begin
                        highest_next = port_reg;
                    end
                end
                else
                begin
                    enable_next[port_reg] = 1'b0;
                end
            end
            MODE_CLEAR:
            begin
                enable_next  = '0;
                highest_next = '0;
            end
            MODE_REQUEST:
            begin
                if (batch_reg == '0)
                begin
                    scan_next = '0;
                end
                if (work == '0)
                begin
                    res_status = ST_NONE;
                end
                else if (cand == '0)
                begin
                    res_status = ST_RANGE;
                end
                else
                begin
                    batch_next       = work;
                    batch_next[pick] = 1'b0;
                    scan_next        = {1'b0, pick} + SCAN_W'(1);
                    res_status       = ST_SERVED;
                    res_port         = pick;
                end
            end
            default:
            begin
                res_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            enable_reg    <= '0;
            highest_reg   <= '0;
            batch_reg     <= '0;
            scan_reg      <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (stage_fire)
            begin
                out_valid_reg <= 1'b1;
                enable_reg    <= enable_next;
                highest_reg   <= highest_next;
                batch_reg     <= batch_next;
                scan_reg      <= scan_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            mode_reg  <= mode_t'(s_axis_tuser);
            port_reg  <= s_axis_tdata[PORT_W-1:0];
            ready_reg <= s_axis_tdata[PORT_W+LINE_W-1:PORT_W];
        end
        if (stage_fire)
        begin
            out_status_reg <= res_status;
            out_port_reg   <= res_port;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-PORT_W){1'b0}}, out_port_reg};
    assign m_axis_tuser  = out_status_reg;

    a_served_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && res_status == ST_SERVED |=> !batch_reg[$past(res_port)])
        else $error("served port still pending");

    a_served_above_scan: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && res_status == ST_SERVED && batch_reg != '0
        |-> {1'b0, res_port} >= scan_reg)
        else $error("served port below scan pointer");

    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && mode_reg == MODE_CLEAR |=> enable_reg == '0 && highest_reg == '0)
        else $error("clear-all left enabled ports");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !stage_fire |=> in_valid_reg)
        else $error("stalled input item dropped");

    a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && res_status == ST_NONE |=> batch_reg == '0)
        else $error("empty snapshot left a batch");

endmodule
